// ----- rtl/i2cmbe_pkg.sv -----
package i2cmbe_pkg;

  // Width of the tick counters and of the timing registers
  localparam int CNT_W      = 10;
  localparam int FUNC_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int BIT_CNT_W  = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CNT_W-1:0] HALF_BIT_RESET = CNT_W'(20);
  localparam logic [CNT_W-1:0] BUS_FREE_RESET = CNT_W'(60);

  // Bit counter: data bits are 0..7, bit 8 is the ACK bit
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = BIT_CNT_W'(8);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT_DONE = BIT_CNT_W'(9);

  // Register index (byte address bit 2)
  localparam logic REG_HALF_BIT_TICKS = 1'b0;
  localparam logic REG_BUS_FREE_TICKS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NACK     = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S1   = 4'd1,
    PH_S2   = 4'd2,
    PH_S3   = 4'd3,
    PH_P1   = 4'd4,
    PH_P2   = 4'd5,
    PH_P3   = 4'd6,
    PH_FREE = 4'd7,
    PH_BA   = 4'd8,
    PH_BB   = 4'd9,
    PH_BC   = 4'd10
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] half_bit_ticks;
    logic [CNT_W-1:0] bus_free_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic              sda_level;
  } tick_t;

  typedef struct packed {
    logic              scl_released;
    logic              sda_released;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [BYTE_W-1:0] read_data;
  } res_t;

endpackage

// ----- rtl/i2cmbe_tick_if.sv -----
interface i2cmbe_tick_if import i2cmbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] data;
  logic              sda_level;

  modport source (output valid, func, data, sda_level, input ready);
  modport sink (input valid, func, data, sda_level, output ready);
endinterface

// ----- rtl/i2cmbe_result_if.sv -----
interface i2cmbe_result_if import i2cmbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_released;
  logic              sda_released;
  logic              busy_res;
  logic              done_res;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, scl_released, sda_released, busy_res, done_res, status,
                  read_data, input ready);
  modport sink (input valid, scl_released, sda_released, busy_res, done_res, status,
                read_data, output ready);
endinterface

// ----- rtl/i2cmbe_cfg.sv -----
module i2cmbe_cfg import i2cmbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks <= HALF_BIT_RESET;
      cfg.bus_free_ticks <= BUS_FREE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_HALF_BIT_TICKS) begin
        cfg.half_bit_ticks <= pwdata[CNT_W-1:0];
      end else begin
        cfg.bus_free_ticks <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUS_FREE_TICKS) begin
      prdata = APB_DATA_W'(cfg.bus_free_ticks);
    end else begin
      prdata = APB_DATA_W'(cfg.half_bit_ticks);
    end
  end

endmodule

// ----- rtl/i2cmbe_engine.sv -----
module i2cmbe_engine import i2cmbe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  tick_t tk,
  input  logic  advance,
  output res_t  res
);

  // Bus and command state
  logic                 scl_line, sda_line;
  phase_t               phase;
  cmd_t                 cmd;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     dly;
  logic [BYTE_W-1:0]    shift_byte;
  logic                 ack_seen;

  // After command launch
  logic                 scl_a, sda_a;
  phase_t               ph_a;
  cmd_t                 cmd_a;
  logic [BIT_CNT_W-1:0] bit_a;
  logic [CNT_W-1:0]     dly_a;
  logic [BYTE_W-1:0]    sh_a;
  logic                 ack_a;

  // After phase end
  logic                 scl_next, sda_next;
  phase_t               phase_next;
  cmd_t                 cmd_next;
  logic [BIT_CNT_W-1:0] bit_cnt_next;
  logic [CNT_W-1:0]     dly_next;
  logic [BYTE_W-1:0]    shift_byte_next;
  logic                 ack_seen_next;

  logic                 is_cmd, launch, rejected, finished, ent;
  phase_t               ent_ph;
  logic [CNT_W-1:0]     half, dly_dec;

  function automatic logic send_bit(input cmd_t c, input logic [BIT_CNT_W-1:0] b,
                                    input logic [BYTE_W-1:0] sh);
    logic r;
    if (c == CMD_WRITE) begin
      r = (b < BITS_PER_BYTE) ? sh[3'd7 - b[2:0]] : 1'b1;
    end else begin
      r = (b < BITS_PER_BYTE) ? 1'b1 : (c == CMD_READ_NACK);
    end
    return r;
  endfunction

  // Line levels on entering a phase; {scl, sda}
  function automatic logic [1:0] enter_lines(input phase_t p, input logic scl,
                                             input logic sda, input logic bsend);
    logic [1:0] r;
    r = {scl, sda};
    case (p)
      PH_S1:   r = 2'b11;
      PH_S2:   r[0] = 1'b0;
      PH_S3:   r[1] = 1'b0;
      PH_P1:   r[0] = 1'b0;
      PH_P2:   r[1] = 1'b1;
      PH_P3:   r[0] = 1'b1;
      PH_BA:   r[0] = bsend;
      PH_BB:   r[1] = 1'b1;
      PH_BC:   r[1] = 1'b0;
      default: r = {scl, sda};
    endcase
    return r;
  endfunction

  assign half     = (cfg.half_bit_ticks == '0) ? CNT_W'(1) : cfg.half_bit_ticks;
  assign is_cmd   = tk.func inside {[CMD_START:CMD_READ_NACK]};
  assign launch   = (phase == PH_IDLE) && is_cmd;
  assign rejected = (phase != PH_IDLE) && is_cmd;

  // Next state
  always_comb begin
    scl_a = scl_line;
    sda_a = sda_line;
    ph_a  = phase;
    cmd_a = cmd;
    bit_a = bit_cnt;
    dly_a = dly;
    sh_a  = shift_byte;
    ack_a = ack_seen;
    if (launch) begin
      cmd_a = cmd_t'(tk.func);
      bit_a = '0;
      ack_a = 1'b0;
      sh_a  = (tk.func == CMD_WRITE) ? tk.data : '0;
      case (tk.func)
        CMD_START: ph_a = PH_S1;
        CMD_STOP:  ph_a = PH_P1;
        default:   ph_a = PH_BA;
      endcase
      dly_a = half;
      {scl_a, sda_a} = enter_lines(ph_a, scl_line, sda_line, send_bit(cmd_a, bit_a, sh_a));
    end

    scl_next        = scl_a;
    sda_next        = sda_a;
    phase_next      = ph_a;
    cmd_next        = cmd_a;
    bit_cnt_next    = bit_a;
    dly_next        = dly_a;
    shift_byte_next = sh_a;
    ack_seen_next   = ack_a;
    finished        = 1'b0;
    ent             = 1'b0;
    ent_ph          = ph_a;
    dly_dec         = dly_a - CNT_W'(1);

    if (ph_a != PH_IDLE) begin
      dly_next = dly_dec;
      if (dly_dec == '0) begin
        case (ph_a)
          PH_S1: begin ent = 1'b1; ent_ph = PH_S2; end
          PH_S2: begin ent = 1'b1; ent_ph = PH_S3; end
          PH_P1: begin ent = 1'b1; ent_ph = PH_P2; end
          PH_P2: begin ent = 1'b1; ent_ph = PH_P3; end
          PH_P3: begin
            if (cfg.bus_free_ticks != '0) begin
              ent    = 1'b1;
              ent_ph = PH_FREE;
            end else begin
              finished = 1'b1;
            end
          end
          PH_BA: begin ent = 1'b1; ent_ph = PH_BB; end
          PH_BB: begin
            // sample SDA at the end of the SCL-high phase
            if (cmd_a == CMD_WRITE) begin
              if (bit_a >= BITS_PER_BYTE) ack_seen_next = !tk.sda_level;
            end else if (bit_a < BITS_PER_BYTE) begin
              shift_byte_next = {sh_a[BYTE_W-2:0], tk.sda_level};
            end
            ent    = 1'b1;
            ent_ph = PH_BC;
          end
          PH_BC: begin
            bit_cnt_next = bit_a + BIT_CNT_W'(1);
            if (bit_cnt_next >= LAST_BIT_DONE) begin
              finished = 1'b1;
            end else begin
              ent    = 1'b1;
              ent_ph = PH_BA;
            end
          end
          default: finished = 1'b1;
        endcase
      end
    end

    if (ent) begin
      phase_next = ent_ph;
      dly_next   = (ent_ph == PH_FREE) ? cfg.bus_free_ticks : half;
      {scl_next, sda_next} = enter_lines(ent_ph, scl_a, sda_a,
                                         send_bit(cmd_a, bit_cnt_next, shift_byte_next));
    end
    if (finished) begin
      phase_next = PH_IDLE;
      cmd_next   = CMD_NONE;
      dly_next   = '0;
    end
  end

  // Result of this tick
  always_comb begin
    res.scl_released = scl_a;
    res.sda_released = sda_a;
    res.busy_res     = (phase_next != PH_IDLE);
    res.done_res     = finished || rejected;
    res.status       = ST_OK;
    res.read_data    = '0;
    if (finished) begin
      if (cmd_a == CMD_WRITE) begin
        res.status = ack_seen_next ? ST_OK : ST_NACK;
      end else if (cmd_a == CMD_READ_ACK || cmd_a == CMD_READ_NACK) begin
        res.read_data = shift_byte_next;
      end
    end else if (rejected) begin
      res.status = ST_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_line   <= 1'b1;
      sda_line   <= 1'b1;
      phase      <= PH_IDLE;
      cmd        <= CMD_NONE;
      bit_cnt    <= '0;
      dly        <= '0;
      shift_byte <= '0;
      ack_seen   <= 1'b0;
    end else if (advance) begin
      scl_line   <= scl_next;
      sda_line   <= sda_next;
      phase      <= phase_next;
      cmd        <= cmd_next;
      bit_cnt    <= bit_cnt_next;
      dly        <= dly_next;
      shift_byte <= shift_byte_next;
      ack_seen   <= ack_seen_next;
    end
  end

endmodule

// ----- rtl/i2c_master_byte_engine_top.sv -----
// I2C master byte engine. Each transfer on the tick channel is one time tick of
// the bus timing and carries an optional command in func (start, stop, write
// byte, read with ACK, read with NACK); every tick gives exactly one transfer on
// the result channel with the SCL/SDA release levels for that tick, busy, and on
// completion done, status and the byte read. A command given while busy is
// answered at once with status "rejected" and the running command goes on; one
// given on the finishing tick is dropped. The engine takes one tick per clock
// cycle while results are taken; a tick's result passes through one input
// register and one result register, and the combinational next-state logic of
// the phase sequencer sets that rate. Timing registers are written over the APB
// port: half_bit_ticks at byte address 0, bus_free_ticks at byte address 4;
// write them only while the engine is idle.
module i2c_master_byte_engine_top import i2cmbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  i2cmbe_tick_if.sink           tick,
  i2cmbe_result_if.source       result
);

  cfg_t  cfg;
  tick_t tick_reg;
  logic  tick_valid;
  logic  advance;
  res_t  res_comb;
  res_t  res_reg;
  logic  res_valid;

  i2cmbe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held tick into the result register when that slot frees up
  assign advance    = tick_valid && (!res_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  // Capture the payload on every accepted transfer
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_reg.func      <= tick.func;
      tick_reg.data      <= tick.data;
      tick_reg.sda_level <= tick.sda_level;
    end
  end

  i2cmbe_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .tk      (tick_reg),
    .advance (advance),
    .res     (res_comb)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  assign result.valid        = res_valid;
  assign result.scl_released = res_reg.scl_released;
  assign result.sda_released = res_reg.sda_released;
  assign result.busy_res     = res_reg.busy_res;
  assign result.done_res     = res_reg.done_res;
  assign result.status       = res_reg.status;
  assign result.read_data    = res_reg.read_data;

endmodule

// ----- rtl/i2cmbe_checker.sv -----
module i2cmbe_checker import i2cmbe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              scl_released,
  input logic              sda_released,
  input logic              busy_res,
  input logic              done_res,
  input logic [1:0]        status,
  input logic [BYTE_W-1:0] read_data
);

  // Status only accompanies a completion or rejection
  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> status == ST_OK)
    else $error("status set without done");

  // A rejection means the running command is still going
  a_reject_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_REJECTED |-> busy_res && done_res)
    else $error("rejection reported while not busy");

  // A NACKed write leaves the engine idle
  a_nack_ends_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_NACK |-> !busy_res)
    else $error("write NACK reported while still busy");

  // Read data only appears on a clean completion
  a_read_data_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_data != '0 |-> done_res && status == ST_OK && !busy_res)
    else $error("read data outside a completed read");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(scl_released)
      && $stable(sda_released) && $stable(busy_res) && $stable(done_res)
      && $stable(status) && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_top i2cmbe_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .scl_released (result.scl_released),
  .sda_released (result.sda_released),
  .busy_res     (result.busy_res),
  .done_res     (result.done_res),
  .status       (result.status),
  .read_data    (result.read_data)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import i2cmbe_pkg::*;

  // Spare func codes: the engine treats them as a plain tick
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // How the sampled SDA level is chosen for a run of ticks
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int RESULT_LATENCY = 2;
  localparam int LONG_HOLD      = 60;
  localparam int SEG_ITEMS      = 140;
  localparam int CYCLE_LIMIT    = 400000;

  // Shadow of the engine: line levels, phase sequencer and timing registers
  typedef struct packed {
    logic              scl;
    logic              sda;
    phase_t            ph;
    logic [FUNC_W-1:0] cmd;
    logic [3:0]        bitc;
    logic [CNT_W-1:0]  dly;
    logic [BYTE_W-1:0] shreg;
    logic              ack;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  free;
  } engine_st_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  i2cmbe_tick_if   tick_ch ();
  i2cmbe_result_if res_ch ();

  i2c_master_byte_engine_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick    (tick_ch),
    .result  (res_ch)
  );

  // line_st follows accepted ticks; sched_st runs ahead over scheduled ticks
  engine_st_t line_st;
  engine_st_t sched_st;
  tick_t      tick_q[$];
  res_t       bus_res_q[$];

  bit tick_held;
  bit calm;
  bit hold_req;
  int send_gap;
  int stall_left;
  int hold_left;
  int n_sched;
  int n_errors;
  int n_res;
  int n_ok;
  int n_nack;
  int n_rej;
  int cycle_cnt;

  // Load a phase: reload the tick count and set the lines that the phase owns
  function automatic void enter_phase(inout engine_st_t s, input phase_t p);
    s.ph  = p;
    s.dly = (s.half == '0) ? CNT_W'(1) : s.half;
    case (p)
      PH_S1: begin
        s.sda = 1'b1;
        s.scl = 1'b1;
      end
      PH_S2: s.sda = 1'b0;
      PH_S3: s.scl = 1'b0;
      PH_P1: s.sda = 1'b0;
      PH_P2: s.scl = 1'b1;
      PH_P3: s.sda = 1'b1;
      PH_FREE: s.dly = s.free;
      PH_BA: begin
        if (s.cmd == CMD_WRITE) begin
          s.sda = (s.bitc < BITS_PER_BYTE) ? s.shreg[7 - s.bitc] : 1'b1;
        end else begin
          s.sda = (s.bitc < BITS_PER_BYTE) ? 1'b1 : (s.cmd == CMD_READ_NACK);
        end
      end
      PH_BB: s.scl = 1'b1;
      PH_BC: s.scl = 1'b0;
      default: ;
    endcase
  endfunction

  // Advance the shadow engine by one tick and return what the bus shows
  function automatic res_t i2c_tick(inout engine_st_t s, input tick_t t);
    res_t r;
    logic is_cmd;
    logic rejected;
    logic finished;
    r        = '0;
    rejected = 1'b0;
    finished = 1'b0;
    is_cmd   = (t.func >= CMD_START) && (t.func <= CMD_READ_NACK);
    if (s.ph == PH_IDLE) begin
      if (is_cmd) begin
        s.cmd   = t.func;
        s.bitc  = '0;
        s.ack   = 1'b0;
        s.shreg = (t.func == CMD_WRITE) ? t.data : '0;
        if (t.func == CMD_START) enter_phase(s, PH_S1);
        else if (t.func == CMD_STOP) enter_phase(s, PH_P1);
        else enter_phase(s, PH_BA);
      end
    end else if (is_cmd) begin
      rejected = 1'b1;
    end
    r.scl_released = s.scl;
    r.sda_released = s.sda;
    if (s.ph != PH_IDLE) begin
      s.dly = s.dly - 1'b1;
      if (s.dly == '0) begin
        case (s.ph)
          PH_S1: enter_phase(s, PH_S2);
          PH_S2: enter_phase(s, PH_S3);
          PH_P1: enter_phase(s, PH_P2);
          PH_P2: enter_phase(s, PH_P3);
          PH_P3: begin
            if (s.free != '0) enter_phase(s, PH_FREE);
            else finished = 1'b1;
          end
          PH_BA: enter_phase(s, PH_BB);
          PH_BB: begin
            // Sample SDA on the last tick of SCL high
            if (s.cmd == CMD_WRITE) begin
              if (s.bitc >= BITS_PER_BYTE) s.ack = ~t.sda_level;
            end else if (s.bitc < BITS_PER_BYTE) begin
              s.shreg = {s.shreg[BYTE_W-2:0], t.sda_level};
            end
            enter_phase(s, PH_BC);
          end
          PH_BC: begin
            s.bitc = s.bitc + 1'b1;
            if (s.bitc >= LAST_BIT_DONE) finished = 1'b1;
            else enter_phase(s, PH_BA);
          end
          default: finished = 1'b1;
        endcase
      end
    end
    if (finished) begin
      r.done_res = 1'b1;
      if (s.cmd == CMD_WRITE) begin
        r.status = s.ack ? ST_OK : ST_NACK;
      end else if (s.cmd == CMD_READ_ACK || s.cmd == CMD_READ_NACK) begin
        r.read_data = s.shreg;
      end
      s.ph  = PH_IDLE;
      s.cmd = CMD_NONE;
      s.dly = '0;
    end else if (rejected) begin
      r.done_res = 1'b1;
      r.status   = ST_REJECTED;
    end
    r.busy_res = (s.ph != PH_IDLE);
    return r;
  endfunction

  function automatic logic pick_sda(input int mode);
    if (mode == SDA_RAND) return 1'($urandom_range(0, 1));
    return (mode == SDA_HIGH);
  endfunction

  // Schedule one tick and run the look-ahead shadow over it
  task automatic push_tick(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
                           input logic sda);
    tick_t t;
    t = '{f, d, sda};
    void'(i2c_tick(sched_st, t));
    tick_q.push_back(t);
    n_sched++;
  endtask

  // Tick the engine until the scheduled command is over. Sprinkle commands
  // into the busy stretch (rejections) and onto the finishing tick (dropped).
  task automatic fill_to_idle(input int sda_mode, input int rej_pct, input int clash_pct);
    engine_st_t        peek;
    res_t              r;
    logic              sda;
    logic [FUNC_W-1:0] f;
    while (sched_st.ph != PH_IDLE) begin
      sda  = pick_sda(sda_mode);
      peek = sched_st;
      r    = i2c_tick(peek, '{CMD_NONE, 8'h00, sda});
      if (r.done_res && $urandom_range(0, 99) < clash_pct) begin
        f = FUNC_W'($urandom_range(CMD_START, CMD_READ_NACK));
      end else if ($urandom_range(0, 99) < rej_pct) begin
        f = FUNC_W'($urandom_range(CMD_START, FUNC_SPARE_HI));
      end else if ($urandom_range(0, 19) == 0) begin
        f = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      end else begin
        f = CMD_NONE;
      end
      push_tick(f, 8'($urandom), sda);
    end
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
                       input int sda_mode, input int rej_pct, input int clash_pct);
    push_tick(f, d, pick_sda(sda_mode));
    fill_to_idle(sda_mode, rej_pct, clash_pct);
  endtask

  // Mostly framed transactions: START, one to three bytes, STOP. The rest is
  // stray func codes, commands among them, that break the framing.
  task automatic random_traffic(input int n);
    int base;
    int k;
    base = n_sched;
    while (n_sched - base < n) begin
      if ($urandom_range(0, 99) < 85) begin
        issue(CMD_START, 8'($urandom), SDA_RAND, 5, 10);
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, 3);
          if (k < 2) issue(CMD_WRITE, 8'($urandom), SDA_RAND, 5, 10);
          else if (k == 2) issue(CMD_READ_ACK, 8'($urandom), SDA_RAND, 5, 10);
          else issue(CMD_READ_NACK, 8'($urandom), SDA_RAND, 5, 10);
        end
        issue(CMD_STOP, 8'($urandom), SDA_RAND, 5, 10);
      end else begin
        issue(FUNC_W'($urandom_range(0, 7)), 8'($urandom), SDA_RAND, 20, 20);
      end
    end
  endtask

  // Wait for the engine to drain: nothing left to send, nothing awaited
  task automatic settle();
    while (tick_q.size() != 0 || tick_held || bus_res_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // APB write with junk above the counter width, then read back
  task automatic write_reg(input logic sel, input logic [CNT_W-1:0] val);
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] want;
    want = APB_DATA_W'(val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= ($urandom & ~APB_DATA_W'(10'h3FF)) | want;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_HALF_BIT_TICKS) begin
      line_st.half  = val;
      sched_st.half = val;
    end else begin
      line_st.free  = val;
      sched_st.free = val;
    end
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd !== want) begin
      $display("%0t: register %0d read back: expected %h, got %h", $time, sel, want, rd);
      n_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung handshake
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Tick sender: present the next queued tick, with short random gaps
  always @(negedge clk) begin : drive_ticks
    tick_t nxt;
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_held) begin
      if (send_gap > 0) begin
        send_gap--;
        tick_ch.valid <= 1'b0;
      end else if (tick_q.size() == 0) begin
        tick_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 2);
        tick_ch.valid <= 1'b0;
      end else begin
        nxt = tick_q.pop_front();
        tick_ch.func      <= nxt.func;
        tick_ch.data      <= nxt.data;
        tick_ch.sda_level <= nxt.sda_level;
        tick_ch.valid     <= 1'b1;
        tick_held = 1'b1;
      end
    end
  end

  // Result receiver: random short stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req) begin
        hold_left = LONG_HOLD - 1;
        hold_req  = 1'b0;
      end else begin
        hold_left--;
      end
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Predict on each accepted tick; check each accepted result in order
  always @(posedge clk) begin : track
    res_t got;
    res_t want;
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) begin
        bus_res_q.push_back(i2c_tick(line_st,
                                     '{tick_ch.func, tick_ch.data, tick_ch.sda_level}));
        tick_held = 1'b0;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.scl_released, res_ch.sda_released, res_ch.busy_res,
               res_ch.done_res, res_ch.status, res_ch.read_data};
        n_res++;
        if (bus_res_q.size() == 0) begin
          $display("%0t: result with none awaited: expected nothing, got %h", $time, got);
          n_errors++;
        end else begin
          want = bus_res_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected scl %b sda %b busy %b done %b st %0d rd %h,",
                     $time, want.scl_released, want.sda_released, want.busy_res,
                     want.done_res, want.status, want.read_data);
            $display("%0t:                  got      scl %b sda %b busy %b done %b st %0d rd %h",
                     $time, got.scl_released, got.sda_released, got.busy_res,
                     got.done_res, got.status, got.read_data);
            n_errors++;
          end
          if (want.done_res) begin
            if (want.status == ST_OK) n_ok++;
            else if (want.status == ST_NACK) n_nack++;
            else n_rej++;
          end
        end
      end
    end
  end

  initial begin : run
    int seg;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    tick_ch.valid     = 1'b0;
    tick_ch.func      = CMD_NONE;
    tick_ch.data      = '0;
    tick_ch.sda_level = 1'b0;
    res_ch.ready      = 1'b0;
    line_st = '{scl: 1'b1, sda: 1'b1, ph: PH_IDLE, cmd: CMD_NONE, bitc: '0, dly: '0,
                shreg: '0, ack: 1'b0, half: HALF_BIT_RESET, free: BUS_FREE_RESET};
    sched_st = line_st;

    // Hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Timing left at its reset values: a start and a stop with its bus-free gap
    issue(CMD_START, 8'h00, SDA_RAND, 0, 0);
    issue(CMD_STOP, 8'h00, SDA_RAND, 0, 0);
    settle();

    // Fastest timing, no bus-free gap: directed corner cases
    write_reg(REG_HALF_BIT_TICKS, CNT_W'(1));
    write_reg(REG_BUS_FREE_TICKS, CNT_W'(0));
    push_tick(CMD_NONE, 8'h00, 1'b0);
    push_tick(FUNC_SPARE_LO, 8'hFF, 1'b1);
    push_tick(FUNC_SPARE_HI, 8'h5A, 1'b0);
    issue(CMD_STOP, 8'h00, SDA_RAND, 0, 0);         // stop with no start before it
    issue(CMD_START, 8'h00, SDA_RAND, 0, 0);
    issue(CMD_WRITE, 8'hFF, SDA_LOW, 0, 0);         // slave acknowledges
    issue(CMD_WRITE, 8'h00, SDA_HIGH, 0, 0);        // slave does not acknowledge
    issue(CMD_WRITE, 8'hA5, SDA_RAND, 0, 0);
    issue(CMD_READ_ACK, 8'h00, SDA_HIGH, 0, 0);     // all ones
    issue(CMD_READ_NACK, 8'h00, SDA_LOW, 0, 0);     // all zeros
    // Offer every command while a read is running: each one is turned away
    push_tick(CMD_READ_ACK, 8'h00, 1'b1);
    push_tick(CMD_START, 8'h11, 1'b0);
    push_tick(CMD_STOP, 8'h22, 1'b1);
    push_tick(CMD_WRITE, 8'h33, 1'b0);
    push_tick(CMD_READ_ACK, 8'h44, 1'b1);
    push_tick(CMD_READ_NACK, 8'h55, 1'b0);
    fill_to_idle(SDA_RAND, 0, 0);
    // A command landing on the finishing tick is dropped silently
    issue(CMD_START, 8'h00, SDA_RAND, 0, 100);
    issue(CMD_WRITE, 8'hC3, SDA_RAND, 0, 100);
    issue(CMD_STOP, 8'h00, SDA_RAND, 0, 0);

    // Bulk random traffic over a few short timing settings
    for (seg = 0; seg < 4; seg++) begin
      settle();
      write_reg(REG_HALF_BIT_TICKS,
                (seg == 3) ? CNT_W'($urandom_range(1, 4)) : CNT_W'(seg + 1));
      write_reg(REG_BUS_FREE_TICKS, CNT_W'($urandom_range(0, 2 * seg)));
      random_traffic(SEG_ITEMS);
      // Stall the result side while the queue is full so the input backs up
      if (seg % 2 == 0) hold_req = 1'b1;
    end

    // Zero half period acts as one; short bus-free gap
    settle();
    write_reg(REG_HALF_BIT_TICKS, CNT_W'(0));
    write_reg(REG_BUS_FREE_TICKS, CNT_W'(5));
    issue(CMD_START, 8'h00, SDA_RAND, 2, 10);
    issue(CMD_WRITE, 8'($urandom), SDA_RAND, 2, 10);
    issue(CMD_READ_ACK, 8'h00, SDA_RAND, 2, 10);
    issue(CMD_STOP, 8'h00, SDA_RAND, 2, 10);

    // Full-scale register values: write and read back only
    settle();
    write_reg(REG_HALF_BIT_TICKS, CNT_W'(1023));
    write_reg(REG_BUS_FREE_TICKS, CNT_W'(1023));

    // Closing stretch at full rate, no idling on either side
    settle();
    calm = 1'b1;
    write_reg(REG_HALF_BIT_TICKS, CNT_W'(2));
    write_reg(REG_BUS_FREE_TICKS, CNT_W'($urandom_range(0, 3)));
    random_traffic(120);

    settle();
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (bus_res_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, bus_res_q.size());
      n_errors++;
    end

    $display("Covered %0d ticks and %0d results: %0d commands ok, %0d NACKed writes,",
             n_sched, n_res, n_ok, n_nack);
    $display("%0d rejected; half periods of 0 to 20 ticks, full-scale registers, %0d errors",
             n_rej, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_tick_if.sv
rtl/i2cmbe_result_if.sv
rtl/i2cmbe_cfg.sv
rtl/i2cmbe_engine.sv
rtl/i2c_master_byte_engine_top.sv
rtl/i2cmbe_checker.sv
tb/sv/tb_top.sv
